// ===== rtl/hsvrgb_pkg.sv =====
// Shared constants and types for the HSV to RGB pixel converter.
// No dependencies; used by rtl/hsv_to_rgb_convert.sv.
`default_nettype none

package hsvrgb_pkg;

  localparam int HUE_W  = 9;
  localparam int CH_W   = 8;
  localparam int FRAC_W = 6;
  localparam int PROD_W = 2 * CH_W;             // v*s and v*(255-s)
  localparam int NUM_W  = 22;                   // 60*v*255 fits below 2**22
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 32;
  localparam int QPROD_W     = NUM_W + RECIP_W;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  localparam logic [CH_W-1:0]    FULL_SCALE = 8'd255;
  localparam logic [FRAC_W-1:0]  SECTOR_DEG = 6'd60;
  localparam logic [HUE_W-1:0]   FULL_TURN  = 9'd360;
  localparam logic [NUM_W-1:0]   DIVISOR    = 22'd15300;   // 60 * 255
  // floor(2**32 / 15300): estimate is exact or one low for every numerator
  localparam logic [RECIP_W-1:0] RECIP      = 19'd280716;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

endpackage

`default_nettype wire

// ===== rtl/hsv_to_rgb_convert.sv =====
// HSV to RGB pixel converter, four register stages.
// Throughput 1 pixel per cycle while m_tready does not stall the output.
// Stages: hue sector + two 8x8 products, interpolation numerators,
// reciprocal multiply, remainder correction + channel select into output register.
// Reset clears the stage valid bits only; datapath registers are not reset.
// Depends on rtl/hsvrgb_pkg.sv.
`default_nettype none

module hsv_to_rgb_convert (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // hue[8:0], saturation[16:9], brightness[24:17], zeros
  input  wire logic [hsvrgb_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [hsvrgb_pkg::M_TDATA_W-1:0]        m_tdata    // red[7:0], green[15:8], blue[23:16]
);

  localparam int CW = hsvrgb_pkg::CH_W;
  localparam int PW = hsvrgb_pkg::PROD_W;
  localparam int NW = hsvrgb_pkg::NUM_W;
  localparam int FW = hsvrgb_pkg::FRAC_W;
  localparam int HW = hsvrgb_pkg::HUE_W;
  localparam int QW = hsvrgb_pkg::QPROD_W;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // each stage loads when empty or when the next one moves
  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // ---------------- stage 1: sector, fraction, products
  logic [HW-1:0] in_hue, hue_w, sec_base, frac_wide;
  logic [CW-1:0] in_sat, in_bri;
  hsvrgb_pkg::sector_t sec_c;

  assign in_hue = s_tdata[8:0];
  assign in_sat = s_tdata[16:9];
  assign in_bri = s_tdata[24:17];

  always_comb begin
    hue_w = (in_hue >= hsvrgb_pkg::FULL_TURN) ? in_hue - hsvrgb_pkg::FULL_TURN : in_hue;
    if (hue_w >= 9'd300) begin
      sec_c = hsvrgb_pkg::SEC_M_TO_R; sec_base = 9'd300;
    end else if (hue_w >= 9'd240) begin
      sec_c = hsvrgb_pkg::SEC_B_TO_M; sec_base = 9'd240;
    end else if (hue_w >= 9'd180) begin
      sec_c = hsvrgb_pkg::SEC_C_TO_B; sec_base = 9'd180;
    end else if (hue_w >= 9'd120) begin
      sec_c = hsvrgb_pkg::SEC_G_TO_C; sec_base = 9'd120;
    end else if (hue_w >= 9'd60) begin
      sec_c = hsvrgb_pkg::SEC_Y_TO_G; sec_base = 9'd60;
    end else begin
      sec_c = hsvrgb_pkg::SEC_R_TO_Y; sec_base = 9'd0;
    end
    frac_wide = hue_w - sec_base;
  end

  hsvrgb_pkg::sector_t sec1, sec2, sec3;
  logic [FW-1:0] frac1;
  logic [PW-1:0] a1, b1;     // a = v*(255-s), b = v*s
  logic [CW-1:0] bri1, bri2, bri3;

  always_ff @(posedge clk) begin
    if (en1) begin
      sec1  <= sec_c;
      frac1 <= frac_wide[FW-1:0];
      a1    <= PW'(in_bri) * PW'(hsvrgb_pkg::FULL_SCALE - in_sat);
      b1    <= PW'(in_bri) * PW'(in_sat);
      bri1  <= in_bri;
    end
  end

  // ---------------- stage 2: numerators and minimum channel
  logic [FW-1:0] k_dn;
  logic [PW:0]   lo_sum;
  assign k_dn   = hsvrgb_pkg::SECTOR_DEG - frac1;
  // x/255 == (x + 1 + (x >> 8)) >> 8 for x <= 255*255
  assign lo_sum = {1'b0, a1} + (PW+1)'(a1[PW-1:CW]) + (PW+1)'(1);

  logic [NW-1:0] num_up2, num_dn2, num_up3, num_dn3;
  logic [CW-1:0] lo2, lo3;

  always_ff @(posedge clk) begin
    if (en2) begin
      num_up2 <= NW'(hsvrgb_pkg::SECTOR_DEG) * NW'(a1) + NW'(frac1) * NW'(b1);
      num_dn2 <= NW'(hsvrgb_pkg::SECTOR_DEG) * NW'(a1) + NW'(k_dn) * NW'(b1);
      lo2     <= lo_sum[PW-1:CW];
      sec2    <= sec1;
      bri2    <= bri1;
    end
  end

  // ---------------- stage 3: quotient estimate by reciprocal
  logic [QW-1:0] qp_up, qp_dn;
  logic [CW-1:0] qe_up3, qe_dn3;
  assign qp_up = QW'(num_up2) * QW'(hsvrgb_pkg::RECIP);
  assign qp_dn = QW'(num_dn2) * QW'(hsvrgb_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (en3) begin
      qe_up3  <= qp_up[hsvrgb_pkg::RECIP_SHIFT +: CW];
      qe_dn3  <= qp_dn[hsvrgb_pkg::RECIP_SHIFT +: CW];
      num_up3 <= num_up2;
      num_dn3 <= num_dn2;
      lo3     <= lo2;
      sec3    <= sec2;
      bri3    <= bri2;
    end
  end

  // ---------------- stage 4: one-step correction, channel routing
  logic [NW-1:0] rem_up, rem_dn, rem_up_fix, rem_dn_fix;
  logic [CW-1:0] up, dn, red_c, green_c, blue_c;

  always_comb begin
    rem_up = num_up3 - NW'(qe_up3) * hsvrgb_pkg::DIVISOR;
    rem_dn = num_dn3 - NW'(qe_dn3) * hsvrgb_pkg::DIVISOR;
    if (rem_up >= hsvrgb_pkg::DIVISOR) begin
      up = qe_up3 + CW'(1); rem_up_fix = rem_up - hsvrgb_pkg::DIVISOR;
    end else begin
      up = qe_up3;          rem_up_fix = rem_up;
    end
    if (rem_dn >= hsvrgb_pkg::DIVISOR) begin
      dn = qe_dn3 + CW'(1); rem_dn_fix = rem_dn - hsvrgb_pkg::DIVISOR;
    end else begin
      dn = qe_dn3;          rem_dn_fix = rem_dn;
    end

    case (sec3)
      hsvrgb_pkg::SEC_R_TO_Y: begin red_c = bri3; green_c = up;   blue_c = lo3;  end
      hsvrgb_pkg::SEC_Y_TO_G: begin red_c = dn;   green_c = bri3; blue_c = lo3;  end
      hsvrgb_pkg::SEC_G_TO_C: begin red_c = lo3;  green_c = bri3; blue_c = up;   end
      hsvrgb_pkg::SEC_C_TO_B: begin red_c = lo3;  green_c = dn;   blue_c = bri3; end
      hsvrgb_pkg::SEC_B_TO_M: begin red_c = up;   green_c = lo3;  blue_c = bri3; end
      default:                begin red_c = bri3; green_c = lo3;  blue_c = dn;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      m_tdata <= {blue_c, green_c, red_c};
    end
  end

  assign m_tvalid = v4;

  // ---------------- checks
  a_rem_fixed: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (rem_up_fix < hsvrgb_pkg::DIVISOR) && (rem_dn_fix < hsvrgb_pkg::DIVISOR))
    else $error("quotient correction left remainder out of range");

  a_lo_le_max: assert property (@(posedge clk) disable iff (rst)
    v2 |-> lo2 <= bri2)
    else $error("minimum channel above brightness");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> sec1 <= hsvrgb_pkg::SEC_M_TO_R)
    else $error("sector out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v4 |-> s_tready)
    else $error("input stalled while output stage empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
